// File: rtl/techo_pkg.sv
// Shared constants for the tape echo with ladder feedback.
`timescale 1ns / 1ps

package techo_pkg;

  localparam int unsigned DelayDepth = 65536;
  localparam int unsigned DelayAw    = 16;
  localparam int unsigned FillW      = DelayAw + 1;

  localparam logic [23:0] DelayCap = 24'(((DelayDepth - 2) * 256));

  localparam logic [23:0] BaseDelayRst  = 24'd3686400;
  localparam logic [23:0] MinDelayRst   = 24'd245760;
  localparam logic [15:0] FbGainRst     = 16'd32768;
  localparam logic [31:0] PhaseStepRst  = 32'd107374;
  localparam logic [23:0] LfoDepthRst   = 24'd36864;
  localparam logic [17:0] LadderGainRst = 18'd1290;
  localparam logic [15:0] ResonanceRst  = 16'd22938;
  localparam logic [15:0] InScaleRst    = 16'd60378;

  localparam logic [3:0] RegBaseDelay  = 4'd0;
  localparam logic [3:0] RegMinDelay   = 4'd1;
  localparam logic [3:0] RegFbGain     = 4'd2;
  localparam logic [3:0] RegPhaseStep  = 4'd3;
  localparam logic [3:0] RegLfoDepth   = 4'd4;
  localparam logic [3:0] RegLadderGain = 4'd5;
  localparam logic [3:0] RegResonance  = 4'd6;
  localparam logic [3:0] RegInScale    = 4'd7;

  localparam logic [32:0] SinC1 = 33'd1686629713;
  localparam logic [32:0] SinC3 = 33'd693598671;
  localparam logic [32:0] SinC5 = 33'd85569278;
  localparam logic [32:0] SinC7 = 33'd5026937;
  localparam logic [32:0] SinC9 = 33'd172228;

  localparam logic [56:0] PadeK0 = 57'(135135) << 36;
  localparam logic [25:0] PadeN1 = 26'd17325;
  localparam logic [25:0] PadeD1 = 26'd62370;
  localparam logic [25:0] PadeN2 = 26'd378;
  localparam logic [25:0] PadeD2 = 26'd3150;

  localparam logic [25:0] WetQ15 = 26'd22938;

endpackage

// File: rtl/tape_echo_with_ladder_feedback.sv
// Tape echo top level: LFO, modulated delay memory, ladder filter, mixer.
`timescale 1ns / 1ps

// One dry word in, one mixed word out. One shared 36x26 multiplier steps
// through the sine polynomial, the delay interpolation, and for each of
// the four ladder stages a Pade tanh whose quotient comes from a
// restoring divider. in_ready_o is high only while the sequencer is idle;
// the output register holds a result until it is taken. The delay memory
// has no clearing pass: a fill count makes slots not yet written since
// reset read as zero, so the block is ready right after reset.
module tape_echo_with_ladder_feedback (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] dry_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] mixed_sample_o,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i
);

  localparam logic [4:0] StIdle = 5'd0;
  localparam logic [4:0] StJ2   = 5'd1;
  localparam logic [4:0] StP9   = 5'd2;
  localparam logic [4:0] StP7   = 5'd3;
  localparam logic [4:0] StP5   = 5'd4;
  localparam logic [4:0] StP3   = 5'd5;
  localparam logic [4:0] StP1   = 5'd6;
  localparam logic [4:0] StSin  = 5'd7;
  localparam logic [4:0] StMod  = 5'd8;
  localparam logic [4:0] StPos  = 5'd9;
  localparam logic [4:0] StRdA  = 5'd10;
  localparam logic [4:0] StRdB  = 5'd11;
  localparam logic [4:0] StInt  = 5'd12;
  localparam logic [4:0] StRes  = 5'd13;
  localparam logic [4:0] StScl  = 5'd14;
  localparam logic [4:0] StGst  = 5'd15;
  localparam logic [4:0] StArg  = 5'd16;
  localparam logic [4:0] StMm   = 5'd17;
  localparam logic [4:0] StSs   = 5'd18;
  localparam logic [4:0] StSss  = 5'd19;
  localparam logic [4:0] StN1   = 5'd20;
  localparam logic [4:0] StD1   = 5'd21;
  localparam logic [4:0] StN2   = 5'd22;
  localparam logic [4:0] StD2   = 5'd23;
  localparam logic [4:0] StDen  = 5'd24;
  localparam logic [4:0] StDiv  = 5'd25;
  localparam logic [4:0] StMq   = 5'd26;
  localparam logic [4:0] StY    = 5'd27;
  localparam logic [4:0] StFb   = 5'd28;
  localparam logic [4:0] StWr   = 5'd29;
  localparam logic [4:0] StOut  = 5'd30;

  logic [4:0] state_q, state_d;

  logic [23:0] base_q, min_q, depth_q;
  logic [15:0] fb_q, res_q, scale_q;
  logic [31:0] step_q;
  logic [17:0] gain_q;

  logic [31:0] ph_q;
  logic [techo_pkg::DelayAw-1:0] wr_q;
  logic [techo_pkg::FillW-1:0] fill_q;
  logic signed [15:0] stg_q [4];
  logic [1:0] k_q;

  logic signed [15:0] x_q, out_q, a_q, dly_q;
  logic [16:0] j2_q, s_q, q_q;
  logic [23:0] mod_q;
  logic [techo_pkg::DelayAw-1:0] ri_q;
  logic [7:0] frac_q;
  logic signed [23:0] u_q;
  logic neg_q;
  logic [14:0] m_q;
  logic [32:0] ss_q;
  logic [48:0] sss_q;
  logic [56:0] n_q, rem_q;
  logic [57:0] d_q;
  logic [4:0] cnt_q;
  logic out_valid_q;

  logic signed [35:0] ma;
  logic signed [25:0] mb;
  logic signed [61:0] p_q;

  logic [15:0] mem [techo_pkg::DelayDepth];
  logic [15:0] rd_q;
  logic [techo_pkg::DelayAw-1:0] mem_ra;
  logic mem_we;

  // LFO and sine
  logic [9:0] idx;
  logic [8:0] jn;
  logic signed [35:0] poly;
  logic [61:0] vraw;
  logic [14:0] vsat;
  logic signed [16:0] sine;
  // delay
  logic signed [25:0] mod_sum, mod_fl;
  logic [23:0] mod_cl, pos;
  logic signed [15:0] b_val;
  // ladder
  logic signed [21:0] t_val;
  logic signed [24:0] xin, xmag;
  logic [21:0] msh;
  logic [58:0] dsh;
  logic [61:0] yraw;
  logic [14:0] ysat;
  logic signed [17:0] wsum, msum;
  logic signed [15:0] wv, mix;
  logic out_free;

  assign idx  = ph_q[31:22];
  assign jn   = idx[8] ? (9'd256 - {1'b0, idx[7:0]}) : {1'b0, idx[7:0]};
  assign vraw = 62'((p_q >>> 8) + 62'sd16384) >> 15;
  assign vsat = (vraw > 62'd32767) ? 15'd32767 : vraw[14:0];
  assign sine = idx[9] ? -$signed({2'b0, vsat}) : $signed({2'b0, vsat});

  always_comb begin
    case (state_q)
      StP7:    poly = $signed({3'b0, techo_pkg::SinC7}) - 36'(p_q >>> 16);
      StP5:    poly = $signed({3'b0, techo_pkg::SinC5}) - 36'(p_q >>> 16);
      StP3:    poly = $signed({3'b0, techo_pkg::SinC3}) - 36'(p_q >>> 16);
      default: poly = $signed({3'b0, techo_pkg::SinC1}) - 36'(p_q >>> 16);
    endcase
  end

  assign mod_sum = $signed({2'b0, base_q}) + 26'(p_q >>> 15);
  assign mod_fl  = (mod_sum < $signed({2'b0, min_q})) ? $signed({2'b0, min_q}) : mod_sum;
  assign mod_cl  = (mod_fl > $signed({2'b0, techo_pkg::DelayCap})) ? techo_pkg::DelayCap :
                   (mod_fl < 26'sd0) ? 24'd0 : mod_fl[23:0];
  assign pos     = {wr_q, 8'd0} - mod_q;

  assign b_val = ({1'b0, ri_q + 1'b1} < fill_q) ? $signed(rd_q) : 16'sd0;

  assign t_val = 22'(dly_q) - 22'(p_q >>> 13);
  assign xin   = 25'(u_q) + 25'(p_q >>> 14);
  assign xmag  = (xin < 25'sd0) ? -xin : xin;
  assign msh   = 22'(xmag >>> 3);
  assign dsh   = 59'(d_q[57:16]) << cnt_q;
  assign yraw  = 62'(p_q >>> 13);
  assign ysat  = (yraw > 62'd32767) ? 15'd32767 : yraw[14:0];

  assign wsum = 18'(x_q) + 18'(p_q >>> 16);
  assign msum = 18'(x_q) + 18'(p_q >>> 15);
  assign wv   = (wsum > 18'sd32767) ? 16'sh7fff : (wsum < -18'sd32768) ? 16'sh8000 : wsum[15:0];
  assign mix  = (msum > 18'sd32767) ? 16'sh7fff : (msum < -18'sd32768) ? 16'sh8000 : msum[15:0];

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      StJ2:  begin ma = 36'(jn); mb = 26'(jn); end
      StP9:  begin ma = $signed({3'b0, techo_pkg::SinC9}); mb = {9'b0, p_q[16:0]}; end
      StP7, StP5, StP3: begin ma = poly; mb = {9'b0, j2_q}; end
      StP1:  begin ma = poly; mb = 26'(jn); end
      StSin: begin ma = 36'(sine); mb = {2'b0, depth_q}; end
      StRdB: begin ma = 36'(b_val) - 36'(a_q); mb = {18'b0, frac_q}; end
      StInt: begin ma = {20'b0, res_q}; mb = 26'(stg_q[3]); end
      StRes: begin ma = 36'(t_val); mb = {10'b0, scale_q}; end
      StGst: begin ma = {18'b0, gain_q}; mb = 26'(stg_q[k_q]); end
      StMm:  begin ma = {21'b0, m_q}; mb = {11'b0, m_q}; end
      StSs:  begin ma = {19'b0, p_q[28:12]}; mb = {9'b0, p_q[28:12]}; end
      StSss: begin ma = {3'b0, p_q[32:0]}; mb = {9'b0, s_q}; end
      StN1:  begin ma = {19'b0, s_q}; mb = techo_pkg::PadeN1; end
      StD1:  begin ma = {19'b0, s_q}; mb = techo_pkg::PadeD1; end
      StN2:  begin ma = {3'b0, ss_q}; mb = techo_pkg::PadeN2; end
      StD2:  begin ma = {3'b0, ss_q}; mb = techo_pkg::PadeD2; end
      StMq:  begin ma = {21'b0, m_q}; mb = {9'b0, q_q}; end
      StFb:  begin ma = 36'(stg_q[3]); mb = {10'b0, fb_q}; end
      StWr, StOut: begin ma = 36'(dly_q); mb = techo_pkg::WetQ15; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= 62'(ma * mb);
  end

  assign mem_ra = (state_q == StPos) ? pos[23:8] : ri_q + 1'b1;
  assign mem_we = (state_q == StWr);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_q] <= wv;
    end
    rd_q <= mem[mem_ra];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StJ2;
      StJ2:    state_d = StP9;
      StP9:    state_d = StP7;
      StP7:    state_d = StP5;
      StP5:    state_d = StP3;
      StP3:    state_d = StP1;
      StP1:    state_d = StSin;
      StSin:   state_d = StMod;
      StMod:   state_d = StPos;
      StPos:   state_d = StRdA;
      StRdA:   state_d = StRdB;
      StRdB:   state_d = StInt;
      StInt:   state_d = StRes;
      StRes:   state_d = StScl;
      StScl:   state_d = StGst;
      StGst:   state_d = StArg;
      StArg:   state_d = StMm;
      StMm:    state_d = StSs;
      StSs:    state_d = StSss;
      StSss:   state_d = StN1;
      StN1:    state_d = StD1;
      StD1:    state_d = StN2;
      StN2:    state_d = StD2;
      StD2:    state_d = StDen;
      StDen:   state_d = StDiv;
      StDiv:   if (cnt_q == 5'd0) state_d = StMq;
      StMq:    state_d = StY;
      StY:     state_d = (k_q == 2'd3) ? StFb : StGst;
      StFb:    state_d = StWr;
      StWr:    state_d = StOut;
      StOut:   if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      base_q      <= techo_pkg::BaseDelayRst;
      min_q       <= techo_pkg::MinDelayRst;
      fb_q        <= techo_pkg::FbGainRst;
      step_q      <= techo_pkg::PhaseStepRst;
      depth_q     <= techo_pkg::LfoDepthRst;
      gain_q      <= techo_pkg::LadderGainRst;
      res_q       <= techo_pkg::ResonanceRst;
      scale_q     <= techo_pkg::InScaleRst;
      ph_q        <= '0;
      wr_q        <= '0;
      fill_q      <= '0;
      stg_q       <= '{default: 16'sd0};
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          techo_pkg::RegBaseDelay:  base_q  <= cfg_wdata_i[23:0];
          techo_pkg::RegMinDelay:   min_q   <= cfg_wdata_i[23:0];
          techo_pkg::RegFbGain:     fb_q    <= cfg_wdata_i[15:0];
          techo_pkg::RegPhaseStep:  step_q  <= cfg_wdata_i;
          techo_pkg::RegLfoDepth:   depth_q <= cfg_wdata_i[23:0];
          techo_pkg::RegLadderGain: gain_q  <= cfg_wdata_i[17:0];
          techo_pkg::RegResonance:  res_q   <= cfg_wdata_i[15:0];
          techo_pkg::RegInScale:    scale_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == StIdle && in_valid_i) ph_q <= ph_q + step_q;
      if (state_q == StScl) k_q <= 2'd0;
      if (state_q == StY) begin
        stg_q[k_q] <= neg_q ? -$signed({1'b0, ysat}) : $signed({1'b0, ysat});
        k_q        <= k_q + 2'd1;
      end
      if (mem_we) begin
        wr_q <= wr_q + 1'b1;
        if (fill_q != techo_pkg::FillW'(techo_pkg::DelayDepth)) fill_q <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) x_q <= dry_sample_i;
    if (state_q == StP9) j2_q <= p_q[16:0];
    if (state_q == StMod) mod_q <= mod_cl;
    if (state_q == StPos) begin
      ri_q   <= pos[23:8];
      frac_q <= pos[7:0];
    end
    if (state_q == StRdA) a_q <= ({1'b0, ri_q} < fill_q) ? $signed(rd_q) : 16'sd0;
    if (state_q == StInt) dly_q <= a_q + 16'(p_q >>> 8);
    if (state_q == StScl) u_q <= 24'(p_q >>> 16);
    if (state_q == StArg) begin
      neg_q <= xin < 25'sd0;
      m_q   <= (msh > 22'd16384) ? 15'd16384 : msh[14:0];
    end
    if (state_q == StSs) s_q <= p_q[28:12];
    if (state_q == StSss) ss_q <= p_q[32:0];
    if (state_q == StN1) sss_q <= p_q[48:0];
    if (state_q == StD1) n_q <= techo_pkg::PadeK0 + (57'(p_q[31:0]) << 24) + 57'(sss_q);
    if (state_q == StN2) begin
      d_q <= 58'(techo_pkg::PadeK0) + (58'(p_q[32:0]) << 24)
           + (58'(sss_q) << 5) - (58'(sss_q) << 2);
    end
    if (state_q == StD2) n_q <= n_q + (57'(p_q[42:0]) << 12);
    if (state_q == StDen) begin
      d_q   <= d_q + (58'(p_q[44:0]) << 12);
      rem_q <= n_q;
      q_q   <= '0;
      cnt_q <= 5'd16;
    end
    if (state_q == StDiv) begin
      if ({2'b0, rem_q} >= dsh) begin
        rem_q        <= 57'({2'b0, rem_q} - dsh);
        q_q[cnt_q]   <= 1'b1;
      end
      cnt_q <= cnt_q - 5'd1;
    end
    if (state_q == StY) u_q <= 24'(neg_q ? -$signed({1'b0, ysat}) : $signed({1'b0, ysat}));
    if (state_q == StOut && out_free) out_q <= mix;
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = out_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= techo_pkg::FillW'(techo_pkg::DelayDepth))
    else $error("fill count beyond memory depth");

  a_word_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == StJ2)
    else $error("accepted word did not start the sequence");

  a_rose_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StOut))
    else $error("result shown outside the output step");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> !mem_we)
    else $error("two memory writes for one word");

  a_write_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> wr_q == $past(wr_q) + 1'b1)
    else $error("write position did not advance");
`endif

endmodule
